// File: src/pbf_pkg.sv
// Shared constants for the parenthesis balance filter.
// Buffer sizing and character codes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pbf_pkg;

    localparam int MAX_LEN = 64;
    localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int BYTE_W  = 8;

    localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h28;
    localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h29;

endpackage

`default_nettype wire

// File: src/pbf_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while no read is issued. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: src/paren_balance_filter.sv
// Parenthesis balance filter: loads a string into a RAM buffer at one beat
// per cycle, dropping each ')' with no open '(', then reads it back and drops
// unmatched '('. A kept byte passes the RAM read register, then the output
// register; an empty result goes out from ST_EMPTY once the output is free.
// Throughput: load 1 beat/cycle; emit 1 buffer entry/cycle through the single
// RAM read port unless the output stalls; no input is taken while emitting.
// Reset: synchronous, clears load counters, state and output valid; buffer is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module paren_balance_filter (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [pbf_pkg::BYTE_W-1:0] s_tdata,  // [7:0] in_byte
    input  wire logic                      s_tlast,   // in_last
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [pbf_pkg::BYTE_W-1:0]     m_tdata,   // [7:0] out_byte
    output logic                           m_tlast,   // out_last
    output logic [1:0]                     m_tuser    // [0] out_empty, [1] out_truncated
);

    import pbf_pkg::*;

    typedef enum logic [2:0] {
        ST_LOAD  = 3'b001,
        ST_EMIT  = 3'b010,
        ST_EMPTY = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0] stored_reg, stored_next;
    logic [CNT_W-1:0] depth_reg, depth_next;
    logic [CNT_W-1:0] opens_reg, opens_next;
    logic             ovf_reg, ovf_next;
    logic [CNT_W-1:0] keep_reg, keep_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] seen_reg, seen_next;
    logic             pend_reg, pend_next;

    logic              mv_reg, mv_next;
    logic [BYTE_W-1:0] mb_reg, mb_next;
    logic              ml_reg, ml_next;
    logic              me_reg, me_next;
    logic              mt_reg, mt_next;

    // load-side decode
    logic             s_acc, is_open, is_close, drop_close, full, store;
    logic [CNT_W-1:0] ld_stored, ld_depth, ld_opens;
    logic             ld_ovf;

    // emit-side decode
    logic [BYTE_W-1:0] rd_data;
    logic              out_free, q_open, skip, consume, emit, finish, issue;

    assign s_tready = (state_reg == ST_LOAD);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !mv_reg || m_tready;

    always_comb begin
        is_open    = (s_tdata == CH_OPEN);
        is_close   = (s_tdata == CH_CLOSE);
        drop_close = is_close && (depth_reg == '0);
        full       = (stored_reg == CNT_W'(MAX_LEN));
        store      = !drop_close && !full;
        ld_stored  = stored_reg;
        ld_depth   = depth_reg;
        ld_opens   = opens_reg;
        ld_ovf     = ovf_reg | (!drop_close && full);
        if (store) begin
            ld_stored = stored_reg + CNT_W'(1);
            if (is_open) begin
                ld_depth = depth_reg + CNT_W'(1);
                ld_opens = opens_reg + CNT_W'(1);
            end else if (is_close) begin
                ld_depth = depth_reg - CNT_W'(1);
            end
        end
    end

    pbf_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(MAX_LEN)
    ) u_store (
        .clk  (aclk),
        .we   (s_acc && store),
        .waddr(stored_reg[ADDR_W-1:0]),
        .wdata(s_tdata),
        .re   (issue),
        .raddr(idx_reg[ADDR_W-1:0]),
        .rdata(rd_data)
    );

    always_comb begin
        q_open  = (rd_data == CH_OPEN);
        // an open beyond the kept count is one of the trailing unmatched ones
        skip    = q_open && (seen_reg >= keep_reg);
        consume = (state_reg == ST_EMIT) && pend_reg && (skip || out_free);
        emit    = consume && !skip;
        finish  = emit && (rem_reg == CNT_W'(1));
        issue   = (state_reg == ST_EMIT) && !finish && (!pend_reg || consume)
                  && (idx_reg < stored_reg);
    end

    always_comb begin
        state_next  = state_reg;
        stored_next = stored_reg;
        depth_next  = depth_reg;
        opens_next  = opens_reg;
        ovf_next    = ovf_reg;
        keep_next   = keep_reg;
        rem_next    = rem_reg;
        idx_next    = idx_reg;
        seen_next   = seen_reg;
        pend_next   = pend_reg;
        mv_next     = mv_reg && !m_tready;
        mb_next     = mb_reg;
        ml_next     = ml_reg;
        me_next     = me_reg;
        mt_next     = mt_reg;

        unique case (state_reg)
            ST_LOAD: begin
                if (s_acc) begin
                    stored_next = ld_stored;
                    depth_next  = ld_depth;
                    opens_next  = ld_opens;
                    ovf_next    = ld_ovf;
                    if (s_tlast) begin
                        keep_next = ld_opens - ld_depth;
                        rem_next  = ld_stored - ld_depth;
                        idx_next  = '0;
                        seen_next = '0;
                        pend_next = 1'b0;
                        state_next = (ld_stored == ld_depth) ? ST_EMPTY : ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (issue) begin
                    idx_next = idx_reg + CNT_W'(1);
                end
                if (consume && q_open) begin
                    seen_next = seen_reg + CNT_W'(1);
                end
                if (emit) begin
                    mv_next  = 1'b1;
                    mb_next  = rd_data;
                    ml_next  = finish;
                    me_next  = 1'b0;
                    mt_next  = ovf_reg;
                    rem_next = rem_reg - CNT_W'(1);
                end
                if (finish) begin
                    pend_next = 1'b0;
                end else if (issue) begin
                    pend_next = 1'b1;
                end else if (consume) begin
                    pend_next = 1'b0;
                end
                if (finish) begin
                    stored_next = '0;
                    depth_next  = '0;
                    opens_next  = '0;
                    ovf_next    = 1'b0;
                    state_next  = ST_LOAD;
                end
            end
            ST_EMPTY: begin
                if (out_free) begin
                    mv_next     = 1'b1;
                    mb_next     = '0;
                    ml_next     = 1'b1;
                    me_next     = 1'b1;
                    mt_next     = ovf_reg;
                    stored_next = '0;
                    depth_next  = '0;
                    opens_next  = '0;
                    ovf_next    = 1'b0;
                    state_next  = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_LOAD;
            stored_reg <= '0;
            depth_reg  <= '0;
            opens_reg  <= '0;
            ovf_reg    <= 1'b0;
            pend_reg   <= 1'b0;
            mv_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            stored_reg <= stored_next;
            depth_reg  <= depth_next;
            opens_reg  <= opens_next;
            ovf_reg    <= ovf_next;
            pend_reg   <= pend_next;
            mv_reg     <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        keep_reg <= keep_next;
        rem_reg  <= rem_next;
        idx_reg  <= idx_next;
        seen_reg <= seen_next;
        mb_reg   <= mb_next;
        ml_reg   <= ml_next;
        me_reg   <= me_next;
        mt_reg   <= mt_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = mb_reg;
    assign m_tlast  = ml_reg;
    assign m_tuser  = {mt_reg, me_reg};

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// Self-checking bench for paren_balance_filter: streams strings through the
// block and predicts the balanced output with a small scoreboard class.
// Depends on pbf_pkg for the buffer size and the parenthesis codes.
`timescale 1ns / 1ps

module tb;
    import pbf_pkg::*;

    typedef struct {
        logic [BYTE_W-1:0] data;
        bit                last;
        bit                empty;
        bit                trunc;
    } kept_beat_t;

    class balance_scoreboard;
        logic [BYTE_W-1:0] char_buf [MAX_LEN];
        int unsigned       n_stored;
        int unsigned       depth;
        int unsigned       n_open;
        bit                overflow;
        kept_beat_t        kept_q[$];
        int unsigned       errors;
        int unsigned       beats_checked;
        int unsigned       trunc_strings;

        // Load one character; on the last one queue the balanced string.
        // Returns 0 when the block simply ignores the character.
        function bit record_char(logic [BYTE_W-1:0] c, bit last);
            bit          used;
            int unsigned keep_open;
            int unsigned opens_seen;
            kept_beat_t  kb;
            int unsigned n;
            used = 1'b1;
            if (c == CH_CLOSE && depth == 0) begin
                used = 1'b0;
            end else if (n_stored >= MAX_LEN) begin
                overflow = 1'b1;
                used = 1'b0;
            end else begin
                char_buf[n_stored] = c;
                n_stored++;
                if (c == CH_OPEN) begin
                    depth++;
                    n_open++;
                end else if (c == CH_CLOSE) begin
                    depth--;
                end
            end
            if (!last)
                return used;
            // keep only the first n_open - depth opens; the rest never closed
            keep_open = n_open - depth;
            opens_seen = 0;
            n = 0;
            for (int unsigned i = 0; i < n_stored; i++) begin
                if (char_buf[i] == CH_OPEN) begin
                    opens_seen++;
                    if (opens_seen > keep_open)
                        continue;
                end
                kb.data = char_buf[i];
                kb.last = 1'b0;
                kb.empty = 1'b0;
                kb.trunc = overflow;
                kept_q.push_back(kb);
                n++;
            end
            if (n == 0) begin
                kb.data = '0;
                kb.last = 1'b1;
                kb.empty = 1'b1;
                kb.trunc = overflow;
                kept_q.push_back(kb);
            end else begin
                kept_q[kept_q.size()-1].last = 1'b1;
            end
            if (overflow)
                trunc_strings++;
            n_stored = 0;
            depth = 0;
            n_open = 0;
            overflow = 1'b0;
            return used;
        endfunction

        function void check_beat(logic [BYTE_W-1:0] data, logic last, logic empty,
                                 logic trunc);
            kept_beat_t exp_b;
            beats_checked++;
            if (kept_q.size() == 0) begin
                $error("result beat with nothing expected: data=%02h last=%0b", data, last);
                errors++;
                return;
            end
            exp_b = kept_q.pop_front();
            if (last !== exp_b.last) begin
                $error("out_last: expected %0b, got %0b", exp_b.last, last);
                errors++;
            end
            if (empty !== exp_b.empty) begin
                $error("out_empty: expected %0b, got %0b", exp_b.empty, empty);
                errors++;
            end
            if (trunc !== exp_b.trunc) begin
                $error("out_truncated: expected %0b, got %0b", exp_b.trunc, trunc);
                errors++;
            end
            // data carries nothing on an empty-string beat
            if (!exp_b.empty && data !== exp_b.data) begin
                $error("out_byte: expected %02h, got %02h", exp_b.data, data);
                errors++;
            end
        endfunction
    endclass

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [BYTE_W-1:0] s_tdata = '0;
    logic              s_tlast = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [BYTE_W-1:0] m_tdata;
    logic              m_tlast;
    logic [1:0]        m_tuser;

    balance_scoreboard sb = new();
    bit                idle_on = 1'b1;
    int unsigned       stall_left = 0;
    int unsigned       strings_sent = 0;
    int unsigned       items_sent = 0;
    int unsigned       dropped_chars = 0;
    logic [BYTE_W-1:0] str_q[$];

    paren_balance_filter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Result side: check accepted beats, stall in random bursts.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_beat(m_tdata, m_tlast, m_tuser[0], m_tuser[1]);
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 6) == 0) begin
            stall_left = $urandom_range(1, 13) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_char(logic [BYTE_W-1:0] c, bit last);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        if (!sb.record_char(c, last))
            dropped_chars++;
        items_sent++;
    endtask

    task automatic send_string();
        for (int i = 0; i < str_q.size(); i++) begin
            send_char(str_q[i], i == str_q.size() - 1);
        end
        strings_sent++;
    endtask

    function automatic logic [BYTE_W-1:0] pick_char(int unsigned open_pct,
                                                    int unsigned close_pct);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < open_pct)
            return CH_OPEN;
        if (r < open_pct + close_pct)
            return CH_CLOSE;
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    function automatic void build_string(int unsigned len);
        int unsigned open_pct;
        int unsigned close_pct;
        open_pct = $urandom_range(20, 60);
        close_pct = $urandom_range(10, 90 - open_pct);
        str_q.delete();
        for (int unsigned i = 0; i < len; i++)
            str_q.push_back(pick_char(open_pct, close_pct));
    endfunction

    initial begin
        int unsigned len;
        int unsigned drain_cycles;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // lone closer: dropped, empty result
        str_q = '{CH_CLOSE};
        send_string();
        // lone opener: never matched, empty result
        str_q = '{CH_OPEN};
        send_string();
        // inner open left dangling
        str_q = '{CH_OPEN, CH_OPEN, CH_CLOSE};
        send_string();
        // leading closer dropped, trailing opener dropped
        str_q = '{CH_CLOSE, CH_OPEN, 8'h61, CH_CLOSE, CH_OPEN};
        send_string();
        // byte extremes pass through untouched
        str_q = '{8'h00, 8'hFF, CH_CLOSE, 8'h7F};
        send_string();
        str_q = '{8'h61};
        send_string();
        str_q = '{CH_OPEN, CH_CLOSE, CH_OPEN, CH_OPEN, CH_CLOSE, CH_CLOSE};
        send_string();

        // Overflow: fill the buffer, then a closer and a letter past capacity.
        str_q.delete();
        for (int i = 0; i < MAX_LEN; i++)
            str_q.push_back((i % 2 == 0) ? CH_OPEN : BYTE_W'($urandom_range(0, 255)));
        str_q.push_back(CH_CLOSE);
        str_q.push_back(8'h5A);
        send_string();
        // exactly full, last byte is an unmatched closer: no truncation
        build_string(MAX_LEN);
        for (int i = 0; i < MAX_LEN; i++)
            if (str_q[i] == CH_CLOSE || str_q[i] == CH_OPEN)
                str_q[i] = 8'h2E;
        str_q.push_back(CH_CLOSE);
        send_string();

        while (items_sent < 180) begin
            idle_on = (items_sent < 165) && ($urandom_range(0, 3) != 0);
            len = $urandom_range(1, 14);
            build_string(len);
            send_string();
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        drain_cycles = 0;
        while (sb.kept_q.size() != 0 && drain_cycles < 20000) begin
            @(posedge aclk);
            drain_cycles++;
        end
        if (sb.kept_q.size() != 0) begin
            $error("%0d expected result beats never arrived", sb.kept_q.size());
            sb.errors++;
        end
        repeat (16) @(posedge aclk);

        $display("Ran %0d strings of %0d beats (%0d ignored, %0d strings truncated).",
                 strings_sent, items_sent, dropped_chars, sb.trunc_strings);
        $display("Checked %0d result beats.", sb.beats_checked);
        if (sb.errors == 0) begin
            $display("[paren_balance_filter] OK");
        end else begin
            $display("[paren_balance_filter] ERROR");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("[paren_balance_filter] ERROR");
        $finish;
    end

endmodule
